// ----- rtl/core/vajl_pkg.sv -----
// ----------------------------------------------------------------------------
// vajl_pkg
// Shared types, constants and arithmetic helpers of the velocity limiter:
// register map, limit bundle, fixed-point widths, band scaling and clamping.
// ----------------------------------------------------------------------------
package vajl_pkg;

   // Q16.16 field widths
   localparam int unsigned DataW    = 32;
   localparam int unsigned CorrW    = 33;
   localparam int unsigned FracW    = 16;
   // band magnitudes saturate at 2^40
   localparam int unsigned BandW    = 41;
   localparam int unsigned HiProdW  = BandW - FracW + DataW;
   localparam int unsigned LoProdW  = FracW + DataW;
   // signed working width for differences and bands
   localparam int unsigned WideW    = 44;
   localparam int unsigned Diff1W   = 34;
   localparam int unsigned Diff2W   = 36;
   // pipeline depth
   localparam int unsigned NStage   = 9;
   // configuration port
   localparam int unsigned CsrAddrW = 5;
   localparam int unsigned CsrDataW = 32;

   localparam logic [BandW-1:0] BandSat = BandW'(1) << (BandW - 1);
   localparam logic signed [DataW-1:0] CodeMin = {1'b1, {(DataW-1){1'b0}}};
   localparam logic signed [DataW-1:0] CodeMax = {1'b0, {(DataW-1){1'b1}}};

   typedef logic signed [DataW-1:0] q_type;
   typedef logic signed [WideW-1:0] wide_type;

   // register indexes (word address = index)
   typedef enum logic [2:0] {
      REG_VEL_MIN  = 3'd0,
      REG_VEL_MAX  = 3'd1,
      REG_ACC_MIN  = 3'd2,
      REG_ACC_MAX  = 3'd3,
      REG_JERK_MIN = 3'd4,
      REG_JERK_MAX = 3'd5
   } reg_index_type;

   typedef struct packed {
      q_type vel_min;
      q_type vel_max;
      q_type acc_min;
      q_type acc_max;
      q_type jerk_min;
      q_type jerk_max;
   } limits_type;

   // magnitude of a 32-bit code; -2^31 maps to 2^31
   function automatic logic [DataW-1:0] mag32(input q_type v);
      logic [DataW-1:0] r;
      begin
         r = v[DataW-1] ? DataW'(-v) : DataW'(v);
         return r;
      end
   endfunction

   // floor(m*dt/2^16) from its two partial products, saturated at 2^40
   function automatic logic [BandW-1:0] combine_sat(input logic [HiProdW-1:0] hi_prod,
                                                    input logic [LoProdW-1:0] lo_prod);
      logic [HiProdW:0] sum;
      logic [BandW-1:0] r;
      begin
         sum = {1'b0, hi_prod} + (HiProdW+1)'(lo_prod >> FracW);
         if (sum > (HiProdW+1)'(BandSat)) begin
            r = BandSat;
         end else begin
            r = sum[BandW-1:0];
         end
         return r;
      end
   endfunction

   // apply the sign of the limit to a band magnitude
   function automatic wide_type signed_band(input logic [BandW-1:0] mag, input logic neg);
      wide_type ext;
      begin
         ext = wide_type'({{(WideW-BandW){1'b0}}, mag});
         return neg ? -ext : ext;
      end
   endfunction

   // upper bound first, then lower bound
   function automatic wide_type clamp_band(input wide_type d,
                                           input wide_type lo, input logic lo_on,
                                           input wide_type hi, input logic hi_on);
      wide_type r;
      begin
         r = d;
         if (hi_on && (r > hi)) begin
            r = hi;
         end
         if (lo_on && (r < lo)) begin
            r = lo;
         end
         return r;
      end
   endfunction

endpackage

// ----- rtl/core/vajl_csr.sv -----
// ----------------------------------------------------------------------------
// vajl_csr
// Limit register file behind an APB-style port; resets to the unlimited codes.
// ----------------------------------------------------------------------------
module vajl_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [vajl_pkg::CsrAddrW-1:0]     csr_paddr,
   input  logic [vajl_pkg::CsrDataW-1:0]     csr_pwdata,
   output logic [vajl_pkg::CsrDataW-1:0]     csr_prdata,
   output logic                              csr_pready,
   output vajl_pkg::limits_type              limits
);

   vajl_pkg::limits_type  limits_ff;
   vajl_pkg::reg_index_type reg_idx;
   logic                  wr_xfer;

   assign reg_idx    = vajl_pkg::reg_index_type'(csr_paddr[vajl_pkg::CsrAddrW-1:2]);
   assign wr_xfer    = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign limits     = limits_ff;

   // register writes on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.vel_min  <= vajl_pkg::CodeMin;
         limits_ff.vel_max  <= vajl_pkg::CodeMax;
         limits_ff.acc_min  <= vajl_pkg::CodeMin;
         limits_ff.acc_max  <= vajl_pkg::CodeMax;
         limits_ff.jerk_min <= vajl_pkg::CodeMin;
         limits_ff.jerk_max <= vajl_pkg::CodeMax;
      end else if (wr_xfer) begin
         case (reg_idx)
            vajl_pkg::REG_VEL_MIN:  limits_ff.vel_min  <= csr_pwdata;
            vajl_pkg::REG_VEL_MAX:  limits_ff.vel_max  <= csr_pwdata;
            vajl_pkg::REG_ACC_MIN:  limits_ff.acc_min  <= csr_pwdata;
            vajl_pkg::REG_ACC_MAX:  limits_ff.acc_max  <= csr_pwdata;
            vajl_pkg::REG_JERK_MIN: limits_ff.jerk_min <= csr_pwdata;
            vajl_pkg::REG_JERK_MAX: limits_ff.jerk_max <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // read mux; unused addresses read zero
   always_comb begin
      case (reg_idx)
         vajl_pkg::REG_VEL_MIN:  csr_prdata = limits_ff.vel_min;
         vajl_pkg::REG_VEL_MAX:  csr_prdata = limits_ff.vel_max;
         vajl_pkg::REG_ACC_MIN:  csr_prdata = limits_ff.acc_min;
         vajl_pkg::REG_ACC_MAX:  csr_prdata = limits_ff.acc_max;
         vajl_pkg::REG_JERK_MIN: csr_prdata = limits_ff.jerk_min;
         vajl_pkg::REG_JERK_MAX: csr_prdata = limits_ff.jerk_max;
         default:                csr_prdata = '0;
      endcase
   end

endmodule

// ----- rtl/core/vajl_part_mul.sv -----
// ----------------------------------------------------------------------------
// vajl_part_mul
// Registered split multiply of a magnitude by the time step: the part above
// the 16 fraction bits and the 16 fraction bits each get their own product.
// ----------------------------------------------------------------------------
module vajl_part_mul #(
   parameter int unsigned MagW = vajl_pkg::BandW
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic [MagW-1:0]                      mag,
   input  logic [vajl_pkg::DataW-1:0]           step_time,
   output logic [vajl_pkg::HiProdW-1:0]         hi_prod,
   output logic [vajl_pkg::LoProdW-1:0]         lo_prod
);

   localparam int unsigned HiW  = MagW - vajl_pkg::FracW;
   localparam int unsigned HiPW = HiW + vajl_pkg::DataW;

   logic [HiPW-1:0]              hi_prod_ff;
   logic [vajl_pkg::LoProdW-1:0] lo_prod_ff;

   // partial products, held while the stage stalls
   always_ff @(posedge clock) begin
      if (en) begin
         hi_prod_ff <= HiPW'(mag[MagW-1:vajl_pkg::FracW]) * HiPW'(step_time);
         lo_prod_ff <= vajl_pkg::LoProdW'(mag[vajl_pkg::FracW-1:0]) *
                       vajl_pkg::LoProdW'(step_time);
      end
   end

   assign hi_prod = vajl_pkg::HiProdW'(hi_prod_ff);
   assign lo_prod = lo_prod_ff;

endmodule

// ----- rtl/core/vajl_datapath.sv -----
// ----------------------------------------------------------------------------
// vajl_datapath
// Nine-stage limiter pipeline: band scaling by the time step, jerk clamp,
// acceleration clamp, velocity clamp and correction, with per-stage valids.
// ----------------------------------------------------------------------------
module vajl_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  vajl_pkg::limits_type             limits,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  vajl_pkg::q_type                  cmd_vel,
   input  vajl_pkg::q_type                  last_vel,
   input  vajl_pkg::q_type                  older_vel,
   input  logic [vajl_pkg::DataW-1:0]       step_time,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output vajl_pkg::q_type                  limited_vel,
   output logic signed [vajl_pkg::CorrW-1:0] correction
);

   localparam int unsigned NS = vajl_pkg::NStage;

   // stage control
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] stage_en;

   // stage 1: input capture
   vajl_pkg::q_type              cmd1_ff, last1_ff, older1_ff;
   logic [vajl_pkg::DataW-1:0]   dt1_ff;
   // stage 2: first partial products, raw differences
   vajl_pkg::q_type              cmd2_ff, last2_ff;
   logic signed [vajl_pkg::Diff1W-1:0] prev2_ff;
   logic signed [vajl_pkg::Diff2W-1:0] d2_2_ff;
   logic [vajl_pkg::DataW-1:0]   dt2_ff;
   logic                         dtz2_ff;
   logic [vajl_pkg::HiProdW-1:0] jmin_hp, jmax_hp, amin_hp, amax_hp;
   logic [vajl_pkg::LoProdW-1:0] jmin_lp, jmax_lp, amin_lp, amax_lp;
   // stage 3: first scale done
   vajl_pkg::q_type              cmd3_ff, last3_ff;
   logic signed [vajl_pkg::Diff1W-1:0] prev3_ff;
   logic signed [vajl_pkg::Diff2W-1:0] d2_3_ff;
   logic [vajl_pkg::DataW-1:0]   dt3_ff;
   logic                         dtz3_ff;
   logic [vajl_pkg::BandW-1:0]   jmin_p3_ff, jmax_p3_ff;
   vajl_pkg::wide_type           alo3_ff, ahi3_ff;
   // stage 4: second partial products for jerk
   vajl_pkg::q_type              cmd4_ff, last4_ff;
   logic signed [vajl_pkg::Diff1W-1:0] prev4_ff;
   logic signed [vajl_pkg::Diff2W-1:0] d2_4_ff;
   logic                         dtz4_ff;
   vajl_pkg::wide_type           alo4_ff, ahi4_ff;
   logic [vajl_pkg::HiProdW-1:0] jmin_hp2, jmax_hp2;
   logic [vajl_pkg::LoProdW-1:0] jmin_lp2, jmax_lp2;
   // stage 5: jerk bands
   vajl_pkg::q_type              cmd5_ff, last5_ff;
   logic signed [vajl_pkg::Diff1W-1:0] prev5_ff;
   logic signed [vajl_pkg::Diff2W-1:0] d2_5_ff;
   logic                         dtz5_ff;
   vajl_pkg::wide_type           alo5_ff, ahi5_ff, jlo5_ff, jhi5_ff;
   // stage 6: jerk clamp
   vajl_pkg::q_type              cmd6_ff, last6_ff;
   logic signed [vajl_pkg::Diff1W-1:0] prev6_ff;
   logic                         dtz6_ff;
   vajl_pkg::wide_type           alo6_ff, ahi6_ff, d2c6_ff;
   // stage 7: acceleration clamp
   vajl_pkg::q_type              cmd7_ff, last7_ff;
   logic                         dtz7_ff;
   vajl_pkg::wide_type           d1c7_ff;
   // stage 8: velocity before the bound clamp
   vajl_pkg::q_type              cmd8_ff;
   vajl_pkg::wide_type           v8_ff;
   // stage 9: result
   vajl_pkg::q_type              lim9_ff;
   logic signed [vajl_pkg::CorrW-1:0] corr9_ff;

   // unlimited-code decode
   logic jmin_on, jmax_on, amin_on, amax_on;
   assign jmin_on = (limits.jerk_min != vajl_pkg::CodeMin);
   assign jmax_on = (limits.jerk_max != vajl_pkg::CodeMax);
   assign amin_on = (limits.acc_min  != vajl_pkg::CodeMin);
   assign amax_on = (limits.acc_max  != vajl_pkg::CodeMax);

   // a stage loads when empty or when the next one moves on
   always_comb begin
      stage_en[NS-1] = !vld_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NS; k++) begin
            if (stage_en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // stage 1: capture transfer
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         cmd1_ff   <= cmd_vel;
         last1_ff  <= last_vel;
         older1_ff <= older_vel;
         dt1_ff    <= step_time;
      end
   end

   // stage 2: limit times dt, second difference
   vajl_part_mul #(.MagW(vajl_pkg::DataW)) u_mul_jmin (
      .clock(clock), .en(stage_en[1]), .mag(vajl_pkg::mag32(limits.jerk_min)),
      .step_time(dt1_ff), .hi_prod(jmin_hp), .lo_prod(jmin_lp));
   vajl_part_mul #(.MagW(vajl_pkg::DataW)) u_mul_jmax (
      .clock(clock), .en(stage_en[1]), .mag(vajl_pkg::mag32(limits.jerk_max)),
      .step_time(dt1_ff), .hi_prod(jmax_hp), .lo_prod(jmax_lp));
   vajl_part_mul #(.MagW(vajl_pkg::DataW)) u_mul_amin (
      .clock(clock), .en(stage_en[1]), .mag(vajl_pkg::mag32(limits.acc_min)),
      .step_time(dt1_ff), .hi_prod(amin_hp), .lo_prod(amin_lp));
   vajl_part_mul #(.MagW(vajl_pkg::DataW)) u_mul_amax (
      .clock(clock), .en(stage_en[1]), .mag(vajl_pkg::mag32(limits.acc_max)),
      .step_time(dt1_ff), .hi_prod(amax_hp), .lo_prod(amax_lp));

   logic signed [vajl_pkg::Diff1W-1:0] prev1;
   assign prev1 = vajl_pkg::Diff1W'(last1_ff) - vajl_pkg::Diff1W'(older1_ff);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         cmd2_ff  <= cmd1_ff;
         last2_ff <= last1_ff;
         prev2_ff <= prev1;
         d2_2_ff  <= vajl_pkg::Diff2W'(cmd1_ff) - vajl_pkg::Diff2W'(last1_ff) -
                     vajl_pkg::Diff2W'(prev1);
         dt2_ff   <= dt1_ff;
         dtz2_ff  <= (dt1_ff == '0);
      end
   end

   // stage 3: finish first scale; acceleration bands are final here
   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         cmd3_ff    <= cmd2_ff;
         last3_ff   <= last2_ff;
         prev3_ff   <= prev2_ff;
         d2_3_ff    <= d2_2_ff;
         dt3_ff     <= dt2_ff;
         dtz3_ff    <= dtz2_ff;
         jmin_p3_ff <= vajl_pkg::combine_sat(jmin_hp, jmin_lp);
         jmax_p3_ff <= vajl_pkg::combine_sat(jmax_hp, jmax_lp);
         alo3_ff    <= vajl_pkg::signed_band(vajl_pkg::combine_sat(amin_hp, amin_lp),
                                             limits.acc_min[vajl_pkg::DataW-1]);
         ahi3_ff    <= vajl_pkg::signed_band(vajl_pkg::combine_sat(amax_hp, amax_lp),
                                             limits.acc_max[vajl_pkg::DataW-1]);
      end
   end

   // stage 4: jerk band times dt once more
   vajl_part_mul #(.MagW(vajl_pkg::BandW)) u_mul_jmin2 (
      .clock(clock), .en(stage_en[3]), .mag(jmin_p3_ff),
      .step_time(dt3_ff), .hi_prod(jmin_hp2), .lo_prod(jmin_lp2));
   vajl_part_mul #(.MagW(vajl_pkg::BandW)) u_mul_jmax2 (
      .clock(clock), .en(stage_en[3]), .mag(jmax_p3_ff),
      .step_time(dt3_ff), .hi_prod(jmax_hp2), .lo_prod(jmax_lp2));

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         cmd4_ff  <= cmd3_ff;
         last4_ff <= last3_ff;
         prev4_ff <= prev3_ff;
         d2_4_ff  <= d2_3_ff;
         dtz4_ff  <= dtz3_ff;
         alo4_ff  <= alo3_ff;
         ahi4_ff  <= ahi3_ff;
      end
   end

   // stage 5: jerk bands
   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         cmd5_ff  <= cmd4_ff;
         last5_ff <= last4_ff;
         prev5_ff <= prev4_ff;
         d2_5_ff  <= d2_4_ff;
         dtz5_ff  <= dtz4_ff;
         alo5_ff  <= alo4_ff;
         ahi5_ff  <= ahi4_ff;
         jlo5_ff  <= vajl_pkg::signed_band(vajl_pkg::combine_sat(jmin_hp2, jmin_lp2),
                                           limits.jerk_min[vajl_pkg::DataW-1]);
         jhi5_ff  <= vajl_pkg::signed_band(vajl_pkg::combine_sat(jmax_hp2, jmax_lp2),
                                           limits.jerk_max[vajl_pkg::DataW-1]);
      end
   end

   // stage 6: clamp the second difference
   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         cmd6_ff  <= cmd5_ff;
         last6_ff <= last5_ff;
         prev6_ff <= prev5_ff;
         dtz6_ff  <= dtz5_ff;
         alo6_ff  <= alo5_ff;
         ahi6_ff  <= ahi5_ff;
         d2c6_ff  <= vajl_pkg::clamp_band(vajl_pkg::wide_type'(d2_5_ff),
                                          jlo5_ff, jmin_on, jhi5_ff, jmax_on);
      end
   end

   // stage 7: first difference after the jerk stage, clamped
   vajl_pkg::wide_type d1_raw;
   assign d1_raw = vajl_pkg::wide_type'(prev6_ff) + d2c6_ff;

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         cmd7_ff  <= cmd6_ff;
         last7_ff <= last6_ff;
         dtz7_ff  <= dtz6_ff;
         d1c7_ff  <= vajl_pkg::clamp_band(d1_raw, alo6_ff, amin_on, ahi6_ff, amax_on);
      end
   end

   // stage 8: rebuild velocity; zero step bypasses both rate stages
   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         cmd8_ff <= cmd7_ff;
         v8_ff   <= dtz7_ff ? vajl_pkg::wide_type'(cmd7_ff)
                            : vajl_pkg::wide_type'(last7_ff) + d1c7_ff;
      end
   end

   // stage 9: velocity bounds and correction
   vajl_pkg::wide_type v_clamped;
   vajl_pkg::q_type    v_lim;
   assign v_clamped = vajl_pkg::clamp_band(v8_ff,
                                           vajl_pkg::wide_type'(limits.vel_min), 1'b1,
                                           vajl_pkg::wide_type'(limits.vel_max), 1'b1);
   assign v_lim     = v_clamped[vajl_pkg::DataW-1:0];

   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         lim9_ff  <= v_lim;
         corr9_ff <= vajl_pkg::CorrW'(v_lim) - vajl_pkg::CorrW'(cmd8_ff);
      end
   end

   assign limited_vel = lim9_ff;
   assign correction  = corr9_ff;

endmodule

// ----- rtl/core/velocity_accel_jerk_limiter_unit.sv -----
// ----------------------------------------------------------------------------
// velocity_accel_jerk_limiter_unit
// Jerk, acceleration and velocity limiter on a streaming request/response pair
// with an APB-style limit register port.
// ----------------------------------------------------------------------------
// Pipeline: nine stages from request transfer to response valid.
// Throughput: one item per cycle; stages hold and bubbles close on a stall.
// Depth is set by the two chained scale-by-dt multiplies for the jerk band.
// Reset: clears all stage valids; limits return to their unlimited codes.
// ----------------------------------------------------------------------------
module velocity_accel_jerk_limiter_unit (
   input  logic                          clock,
   input  logic                          reset,
   // request: cmd_vel, last_vel, older_vel, step_time from bit 0 up
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [127:0]                  req_tdata,
   // response: limited_vel, correction from bit 0 up, zero padded to 72 bits
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [71:0]                   rsp_tdata,
   // limit registers
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [vajl_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [vajl_pkg::CsrDataW-1:0] csr_pwdata,
   output logic [vajl_pkg::CsrDataW-1:0] csr_prdata,
   output logic                          csr_pready
);

   vajl_pkg::limits_type              limits;
   vajl_pkg::q_type                   limited_vel;
   logic signed [vajl_pkg::CorrW-1:0] correction;

   vajl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .limits      (limits)
   );

   vajl_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .limits      (limits),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .cmd_vel     (req_tdata[31:0]),
      .last_vel    (req_tdata[63:32]),
      .older_vel   (req_tdata[95:64]),
      .step_time   (req_tdata[127:96]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .limited_vel (limited_vel),
      .correction  (correction)
   );

   // pack response fields
   assign rsp_tdata = {7'b0, correction, limited_vel};

endmodule
